/* rtl/core/sdta_pkg.sv */
// Shared types, constants and microcode encodings for the speedometer display
// and trip average block. No dependencies; every other file imports it.
package sdta_pkg;

    // Field widths.
    localparam int SPEED_W = 8;
    localparam int TRIP_W  = 32;

    // Display filter group.
    localparam int GROUP_SIZE = 5;
    localparam int GSUM_W     = $clog2(GROUP_SIZE * 255 + 1);
    localparam int GCNT_W     = $clog2(GROUP_SIZE + 1);
    localparam logic [GCNT_W-1:0] GROUP_LAST = GCNT_W'(GROUP_SIZE);

    // The group mean is a multiply by a rounded-up reciprocal. Four extra
    // fraction bits keep the error below one LSB for any group size up to 16.
    localparam int MEAN_SHIFT = GSUM_W + 4;
    localparam int MEAN_MUL_W = MEAN_SHIFT + 1;
    localparam int MEAN_PROD_W = GSUM_W + MEAN_MUL_W;
    localparam logic [MEAN_MUL_W-1:0] MEAN_MUL =
        MEAN_MUL_W'((2 ** MEAN_SHIFT + GROUP_SIZE - 1) / GROUP_SIZE);

    // Reset value of the display cap register.
    localparam logic [SPEED_W-1:0] DISPLAY_MAX_RST = 8'd240;

    // Trip accumulation stops once the sum passes this value.
    localparam logic [TRIP_W-1:0] TRIP_LIMIT = 32'hFFFF_FFFF - 32'd240;

    // Speed correction y = (s*CORR_LIN + s*s*CORR_SQ + CORR_OFS) / CORR_DIV,
    // evaluated for every 8-bit speed when the design is elaborated.
    localparam int CORR_LIN = 102020;
    localparam int CORR_SQ  = 5;
    localparam int CORR_OFS = 15810;
    localparam int CORR_DIV = 100000;
    localparam int CORR_W   = 9;
    localparam int CORR_N   = 2 ** SPEED_W;

    typedef logic [CORR_W-1:0] t_corr_rom [CORR_N];

    function automatic t_corr_rom build_corr_rom();
        t_corr_rom rom;
        for (int s = 0; s < CORR_N; s++) begin
            rom[s] = CORR_W'((s * CORR_LIN + s * s * CORR_SQ + CORR_OFS) / CORR_DIV);
        end
        return rom;
    endfunction

    localparam t_corr_rom CORR_ROM = build_corr_rom();

    // Trip divider: the trip average never exceeds 255, so only the low
    // quotient bits are developed, one per step.
    localparam int DIV_STEPS = SPEED_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Datapath operations of one microcode step.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_LATCH      = 4'd0;
    localparam logic [OP_W-1:0] OP_GROUP_ADD  = 4'd1;
    localparam logic [OP_W-1:0] OP_GROUP_MUL  = 4'd2;
    localparam logic [OP_W-1:0] OP_GROUP_DONE = 4'd3;
    localparam logic [OP_W-1:0] OP_TRIP_UPD   = 4'd4;
    localparam logic [OP_W-1:0] OP_DIV_INIT   = 4'd5;
    localparam logic [OP_W-1:0] OP_DIV_STEP   = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV_DONE   = 4'd7;
    localparam logic [OP_W-1:0] OP_OUT_LOAD   = 4'd8;

    // Jump conditions.
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NEXT       = 3'd0;
    localparam logic [COND_W-1:0] COND_NO_REQ     = 3'd1;
    localparam logic [COND_W-1:0] COND_GROUP_OPEN = 3'd2;
    localparam logic [COND_W-1:0] COND_NO_DIV     = 3'd3;
    localparam logic [COND_W-1:0] COND_LOOP_MORE  = 3'd4;
    localparam logic [COND_W-1:0] COND_OUT_BUSY   = 3'd5;

    // Program steps.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE       = 4'd0;
    localparam logic [STEP_W-1:0] STEP_GROUP_ADD  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_GROUP_MUL  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_GROUP_DONE = 4'd3;
    localparam logic [STEP_W-1:0] STEP_TRIP_UPD   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DIV_INIT   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DIV_STEP   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DIV_DONE   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_FINISH     = 4'd8;
    localparam int NUM_STEPS = 9;

    // One control word.
    typedef struct packed {
        logic              take_input;
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } t_ctrl;

    // Datapath status used by the jump conditions.
    typedef struct packed {
        logic req_valid;
        logic group_full;
        logic div_go;
        logic loop_more;
        logic out_busy;
    } t_seq_stat;

endpackage

/* rtl/core/sdta_in_if.sv */
// Request channel of the speedometer block: valid/ready plus one input item.
// Depends on sdta_pkg for field widths.
interface sdta_in_if
    import sdta_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] vehicle_speed;
    logic [SPEED_W-1:0] source_speed;
    logic               ignition_on;
    logic               clear_average;

    modport source (
        output valid, vehicle_speed, source_speed, ignition_on, clear_average,
        input  ready
    );
    modport sink (
        input  valid, vehicle_speed, source_speed, ignition_on, clear_average,
        output ready
    );
endinterface

/* rtl/core/sdta_out_if.sv */
// Result channel of the speedometer block: valid/ready plus one result item.
// Depends on sdta_pkg for field widths.
interface sdta_out_if
    import sdta_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] display_speed;
    logic [SPEED_W-1:0] average_speed;

    modport source (
        output valid, display_speed, average_speed,
        input  ready
    );
    modport sink (
        input  valid, display_speed, average_speed,
        output ready
    );
endinterface

/* rtl/core/sdta_seq.sv */
// Microcode sequencer: step counter, control store and jump logic.
// Depends on sdta_pkg for the control word, status struct and step codes.
module sdta_seq
    import sdta_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_seq_stat i_stat,
    output t_ctrl     o_ctrl
);

    // Control store: take_input, op, jump condition, jump target, last step.
    localparam t_ctrl UCODE [NUM_STEPS] = '{
        '{1'b1, OP_LATCH,      COND_NO_REQ,     STEP_IDLE,      1'b0},
        '{1'b0, OP_GROUP_ADD,  COND_NEXT,       STEP_IDLE,      1'b0},
        '{1'b0, OP_GROUP_MUL,  COND_GROUP_OPEN, STEP_TRIP_UPD,  1'b0},
        '{1'b0, OP_GROUP_DONE, COND_NEXT,       STEP_IDLE,      1'b0},
        '{1'b0, OP_TRIP_UPD,   COND_NO_DIV,     STEP_FINISH,    1'b0},
        '{1'b0, OP_DIV_INIT,   COND_NEXT,       STEP_IDLE,      1'b0},
        '{1'b0, OP_DIV_STEP,   COND_LOOP_MORE,  STEP_DIV_STEP,  1'b0},
        '{1'b0, OP_DIV_DONE,   COND_NEXT,       STEP_IDLE,      1'b0},
        '{1'b0, OP_OUT_LOAD,   COND_OUT_BUSY,   STEP_FINISH,    1'b1}
    };
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    t_ctrl             ctrl;
    logic              jump;

    // Fetch the control word; unused step codes behave as the idle step.
    always_comb begin
        if (r_pc <= LAST_STEP) begin
            ctrl = UCODE[r_pc];
        end else begin
            ctrl = UCODE[STEP_IDLE];
        end
    end

    // Jump condition select.
    always_comb begin
        case (ctrl.cond)
            COND_NEXT:       jump = 1'b0;
            COND_NO_REQ:     jump = !i_stat.req_valid;
            COND_GROUP_OPEN: jump = !i_stat.group_full;
            COND_NO_DIV:     jump = !i_stat.div_go;
            COND_LOOP_MORE:  jump = i_stat.loop_more;
            COND_OUT_BUSY:   jump = i_stat.out_busy;
            default:         jump = 1'b0;
        endcase
    end

    // Next step: jump target, program restart after the last step, or fall through.
    always_comb begin
        if (jump) begin
            n_pc = ctrl.target;
        end else if (ctrl.last) begin
            n_pc = STEP_IDLE;
        end else begin
            n_pc = r_pc + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = ctrl;

endmodule

/* rtl/core/speedometer_display_and_trip_average.sv */
// Top level of the speedometer display filter and trip average block.
// Depends on sdta_pkg, sdta_in_if, sdta_out_if and sdta_seq.
//
// One request yields one result. Each request is processed by a short microcode
// program: the latch, group add and group multiply steps, the group done step
// when a display group of five completes, the trip update step, the divider
// steps when a nonzero source speed is added to the trip sum, and the finish
// step that loads the output register. The divider forms sum / count in an
// 8-step shift-subtract loop. Requests are taken one at a time; a new request is
// accepted while the previous result still waits in the output register.
// The display cap register may be written whenever no request is in flight.
module speedometer_display_and_trip_average
    import sdta_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [SPEED_W-1:0] i_cfg_wr_data,
    sdta_in_if.sink            i_in,
    sdta_out_if.source         o_out
);

    t_ctrl     ctrl;
    t_seq_stat stat;

    // Architectural state.
    logic [SPEED_W-1:0]   r_display_max;
    logic [GSUM_W-1:0]    r_group_sum;
    logic [GCNT_W-1:0]    r_group_count;
    logic [SPEED_W-1:0]   r_display_hold;
    logic [TRIP_W-1:0]    r_trip_sum;
    logic [TRIP_W-1:0]    r_trip_count;
    logic [SPEED_W-1:0]   r_average_hold;

    // Working registers.
    logic [DIV_CNT_W-1:0] r_loop;
    logic                 r_out_valid;
    logic [SPEED_W-1:0]   r_vs;
    logic [SPEED_W-1:0]   r_src;
    logic                 r_ign;
    logic                 r_clr;
    logic [MEAN_PROD_W-1:0] r_prod;
    logic [TRIP_W-1:0]    r_rem;
    logic [SPEED_W-1:0]   r_quo;
    logic [SPEED_W-1:0]   r_out_display;
    logic [SPEED_W-1:0]   r_out_average;

    logic                 accept;
    logic                 out_busy;
    logic                 out_load;
    logic [CORR_W-1:0]    corr_raw;
    logic [SPEED_W-1:0]   corr;
    logic [TRIP_W:0]      trip_add;
    logic [TRIP_W-1:0]    trip_next;
    logic                 trip_take;
    logic [TRIP_W:0]      rem_shift;
    logic [TRIP_W:0]      rem_diff;
    logic                 quo_bit;

    sdta_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // Handshake and sequencer status.
    assign i_in.ready = ctrl.take_input;
    assign accept     = ctrl.take_input && i_in.valid;
    assign out_busy   = r_out_valid && !o_out.ready;
    assign out_load   = (ctrl.op == OP_OUT_LOAD) && !out_busy;

    // The divide decision is taken in the trip update step itself, from the
    // request fields and the trip sum before this step changes it.
    always_comb begin
        stat.req_valid  = i_in.valid;
        stat.group_full = (r_group_count == GROUP_LAST);
        stat.div_go     = r_ign && !r_clr && trip_take;
        stat.loop_more  = (r_loop != DIV_LAST);
        stat.out_busy   = out_busy;
    end

    // Corrected speed from the table, capped at the configured maximum.
    assign corr_raw = CORR_ROM[r_vs];
    assign corr     = (corr_raw >= {1'b0, r_display_max}) ? r_display_max
                                                         : corr_raw[SPEED_W-1:0];

    // Saturating trip sum and its freeze condition.
    assign trip_add  = {1'b0, r_trip_sum} + {{(TRIP_W+1-SPEED_W){1'b0}}, r_src};
    assign trip_next = trip_add[TRIP_W] ? {TRIP_W{1'b1}} : trip_add[TRIP_W-1:0];
    assign trip_take = (r_src != '0) && (r_trip_sum <= TRIP_LIMIT);

    // One restoring division step.
    assign rem_shift = {r_rem, r_quo[SPEED_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_trip_count};
    assign quo_bit   = !rem_diff[TRIP_W];

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_max  <= DISPLAY_MAX_RST;
            r_group_sum    <= '0;
            r_group_count  <= '0;
            r_display_hold <= '0;
            r_trip_sum     <= '0;
            r_trip_count   <= '0;
            r_average_hold <= '0;
            r_loop         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_display_max <= i_cfg_wr_data;
            end

            case (ctrl.op)
                OP_GROUP_ADD: begin
                    r_group_sum   <= r_group_sum + GSUM_W'(corr);
                    r_group_count <= r_group_count + GCNT_W'(1);
                end
                OP_GROUP_DONE: begin
                    r_display_hold <= r_prod[MEAN_SHIFT +: SPEED_W];
                    r_group_sum    <= '0;
                    r_group_count  <= '0;
                end
                OP_TRIP_UPD: begin
                    if (!r_ign || r_clr) begin
                        r_trip_sum     <= '0;
                        r_trip_count   <= '0;
                        r_average_hold <= '0;
                    end else if (trip_take) begin
                        r_trip_sum   <= trip_next;
                        r_trip_count <= r_trip_count + TRIP_W'(1);
                    end
                end
                OP_DIV_INIT: begin
                    r_loop <= '0;
                end
                OP_DIV_STEP: begin
                    r_loop <= r_loop + DIV_CNT_W'(1);
                end
                OP_DIV_DONE: begin
                    r_average_hold <= r_quo;
                end
                default: begin
                end
            endcase

            // Output register: filled by the last step, emptied by the sink.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and datapath scratch registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vs  <= i_in.vehicle_speed;
            r_src <= i_in.source_speed;
            r_ign <= i_in.ignition_on;
            r_clr <= i_in.clear_average;
        end

        case (ctrl.op)
            OP_GROUP_MUL: begin
                r_prod <= r_group_sum * MEAN_MUL;
            end
            OP_DIV_INIT: begin
                // The quotient fits in SPEED_W bits, so the high part of the
                // sum is already below the count.
                r_rem <= r_trip_sum >> SPEED_W;
                r_quo <= r_trip_sum[SPEED_W-1:0];
            end
            OP_DIV_STEP: begin
                r_rem <= quo_bit ? rem_diff[TRIP_W-1:0] : rem_shift[TRIP_W-1:0];
                r_quo <= {r_quo[SPEED_W-2:0], quo_bit};
            end
            default: begin
            end
        endcase

        if (out_load) begin
            r_out_display <= r_display_hold;
            r_out_average <= r_average_hold;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.display_speed = r_out_display;
    assign o_out.average_speed = r_out_average;

endmodule

/* rtl/core/sdta_checker.sv */
// Port-level checks for the speedometer display and trip average block,
// attached to the top level by the bind at the end. Depends on sdta_pkg.
module sdta_checker
    import sdta_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [SPEED_W-1:0] i_out_display,
    input logic [SPEED_W-1:0] i_out_average
);

    // A result offered to a stalled sink stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_display) && $stable(i_out_average))
        else $error("result payload changed while stalled");

    // Requests are processed one at a time: no request right after an accepted one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while the previous one is in work");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind speedometer_display_and_trip_average sdta_checker u_sdta_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_display (o_out.display_speed),
    .i_out_average (o_out.average_speed)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the speedometer display filter and trip average block.
// Depends on sdta_pkg, sdta_in_if, sdta_out_if and speedometer_display_and_trip_average.
module testbench;
    import sdta_pkg::*;

    // One request and one result as the block sees them.
    typedef struct packed {
        logic [SPEED_W-1:0] vehicle_speed;
        logic [SPEED_W-1:0] source_speed;
        logic               ignition_on;
        logic               clear_average;
    } t_tick;

    typedef struct packed {
        logic [SPEED_W-1:0] display_speed;
        logic [SPEED_W-1:0] average_speed;
    } t_readout;

    // A directed row; typed rows carry their result written out by hand.
    typedef struct packed {
        t_tick    tick;
        logic     typed;
        t_readout readout;
    } t_drill;

    localparam int NUM_DRILLS      = 16;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 192;
    localparam int MAX_IDLE        = 18;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 20;

    // Directed rows: reset values, speed and cap extremes, skipped zero samples,
    // a completed group, ignition off and clear requests, alternating bit patterns.
    t_drill drill_tab [NUM_DRILLS] = '{
        '{'{8'd0,   8'd0,   1'b0, 1'b0}, 1'b1, '{8'd0,   8'd0}},
        '{'{8'd255, 8'd255, 1'b1, 1'b0}, 1'b1, '{8'd0,   8'd255}},
        '{'{8'd255, 8'd0,   1'b1, 1'b0}, 1'b1, '{8'd0,   8'd255}},
        '{'{8'd255, 8'd1,   1'b1, 1'b0}, 1'b1, '{8'd0,   8'd128}},
        '{'{8'd255, 8'd200, 1'b1, 1'b1}, 1'b1, '{8'd192, 8'd0}},
        '{'{8'd128, 8'd100, 1'b1, 1'b0}, 1'b1, '{8'd192, 8'd100}},
        '{'{8'd1,   8'd255, 1'b0, 1'b0}, 1'b1, '{8'd192, 8'd0}},
        '{'{8'd254, 8'd170, 1'b1, 1'b1}, 1'b1, '{8'd192, 8'd0}},
        '{'{8'd233, 8'd85,  1'b1, 1'b0}, 1'b1, '{8'd192, 8'd85}},
        '{'{8'd232, 8'd170, 1'b1, 1'b0}, 1'b0, '{8'd0,   8'd0}},
        '{'{8'd85,  8'd85,  1'b1, 1'b0}, 1'b0, '{8'd0,   8'd0}},
        '{'{8'd170, 8'd170, 1'b1, 1'b0}, 1'b0, '{8'd0,   8'd0}},
        '{'{8'd15,  8'd240, 1'b1, 1'b0}, 1'b0, '{8'd0,   8'd0}},
        '{'{8'd240, 8'd15,  1'b0, 1'b1}, 1'b0, '{8'd0,   8'd0}},
        '{'{8'd127, 8'd128, 1'b1, 1'b0}, 1'b0, '{8'd0,   8'd0}},
        '{'{8'd128, 8'd127, 1'b1, 1'b0}, 1'b0, '{8'd0,   8'd0}}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [SPEED_W-1:0] cfg_wr_data;

    sdta_in_if  req_if ();
    sdta_out_if res_if ();

    speedometer_display_and_trip_average i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (req_if),
        .o_out         (res_if)
    );

    // Predictor state, mirrored from the block.
    logic [SPEED_W-1:0] display_cap;
    logic [GSUM_W-1:0]  group_acc;
    logic [GCNT_W-1:0]  group_fill;
    logic [SPEED_W-1:0] display_held;
    logic [TRIP_W-1:0]  trip_total;
    logic [TRIP_W-1:0]  trip_samples;
    logic [SPEED_W-1:0] average_held;

    t_readout expected_readouts [$];

    int  error_count     = 0;
    int  requests_sent   = 0;
    int  results_checked = 0;
    int  hold_cycles     = 0;
    int  long_holds      = 0;
    bit  tx_no_gap       = 1'b0;
    bit  rx_no_stall     = 1'b0;

    // Clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, several times the slowest legal run.
    initial begin
        #6_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_readouts.size());
        $display("testbench failed");
        $finish;
    end

    // Advances the predictor by one tick and returns the readout it yields.
    // The trip freeze and the saturating add are kept, though reaching them
    // takes over sixteen million samples.
    function automatic t_readout compute_readout(input t_tick t);
        int unsigned       spd;
        int unsigned       corr;
        logic [TRIP_W:0]   grown;
        spd  = t.vehicle_speed;
        corr = (spd * CORR_LIN + spd * spd * CORR_SQ + CORR_OFS) / CORR_DIV;
        if (corr >= display_cap) corr = display_cap;
        group_acc  = group_acc + GSUM_W'(corr & 32'hFF);
        group_fill = group_fill + 1'b1;
        if (group_fill >= GROUP_LAST) begin
            display_held = SPEED_W'(group_acc / GROUP_SIZE);
            group_acc    = '0;
            group_fill   = '0;
        end
        if (t.ignition_on && t.source_speed != '0 && trip_total <= TRIP_LIMIT) begin
            grown        = {1'b0, trip_total} + t.source_speed;
            trip_total   = grown[TRIP_W] ? '1 : grown[TRIP_W-1:0];
            trip_samples = trip_samples + 1'b1;
            average_held = SPEED_W'(trip_total / trip_samples);
        end
        // Ignition off and a clear request both zero the trip after the update.
        if (!t.ignition_on || t.clear_average) begin
            trip_total   = '0;
            trip_samples = '0;
            average_held = '0;
        end
        return '{display_held, average_held};
    endfunction

    // Offers one request after a random gap and records its expected readout
    // once accepted. Called at a rising edge; returns at the accepting edge.
    task automatic send_request(input t_tick t, input logic typed, input t_readout typed_ro);
        int       gap;
        t_readout ro;
        gap = tx_no_gap ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.vehicle_speed <= t.vehicle_speed;
        req_if.source_speed  <= t.source_speed;
        req_if.ignition_on   <= t.ignition_on;
        req_if.clear_average <= t.clear_average;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        ro = compute_readout(t);
        expected_readouts.push_back(typed ? typed_ro : ro);
        requests_sent++;
    endtask

    // Writes the display cap while the block is idle.
    task automatic write_display_cap(input logic [SPEED_W-1:0] cap);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        display_cap = cap;
    endtask

    // Result side: random stalls, one long hold on request, field checks.
    initial begin : result_sink
        int       stall;
        t_readout got;
        t_readout want;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
                long_holds++;
            end else begin
                stall = rx_no_stall ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
            got = '{res_if.display_speed, res_if.average_speed};
            if (expected_readouts.size() == 0) begin
                $display("%0t: unexpected result, display_speed %0d average_speed %0d",
                         $time, got.display_speed, got.average_speed);
                error_count++;
            end else begin
                want = expected_readouts.pop_front();
                if (got.display_speed !== want.display_speed) begin
                    $display("%0t: display_speed expected %0d, actual %0d",
                             $time, want.display_speed, got.display_speed);
                    error_count++;
                end
                if (got.average_speed !== want.average_speed) begin
                    $display("%0t: average_speed expected %0d, actual %0d",
                             $time, want.average_speed, got.average_speed);
                    error_count++;
                end
                results_checked++;
            end
        end
    end

    // Request side: reset, directed rows, then one random phase per cap setting.
    initial begin : stimulus
        t_tick              t;
        logic [SPEED_W-1:0] cap;
        int                 pick;
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= '0;
        req_if.valid         <= 1'b0;
        req_if.vehicle_speed <= '0;
        req_if.source_speed  <= '0;
        req_if.ignition_on   <= 1'b0;
        req_if.clear_average <= 1'b0;
        display_cap  = DISPLAY_MAX_RST;
        group_acc    = '0;
        group_fill   = '0;
        display_held = '0;
        trip_total   = '0;
        trip_samples = '0;
        average_held = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run with the cap at its reset value.
        for (int r = 0; r < NUM_DRILLS; r++) begin
            send_request(drill_tab[r].tick, drill_tab[r].typed, drill_tab[r].readout);
        end
        req_if.valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Drain before touching the cap.
            while (expected_readouts.size() != 0) @(posedge clk);
            case (p)
                0:       cap = 8'd0;
                1:       cap = 8'd255;
                2:       cap = 8'd1;
                3:       cap = DISPLAY_MAX_RST;
                5:       cap = 8'd233;
                7:       cap = 8'd128;
                default: cap = SPEED_W'($urandom_range(0, 255));
            endcase
            write_display_cap(cap);
            tx_no_gap   = (p % 4 == 1);
            rx_no_stall = (p % 4 == 2);
            // Back-to-back requests against a long result stall fill the block.
            if (p == 3) begin
                tx_no_gap   = 1'b1;
                hold_cycles = LONG_HOLD;
            end
            // Mostly long trips with random speeds; a few off and clear ticks.
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 7);
                case (pick)
                    0:       t.vehicle_speed = '0;
                    1:       t.vehicle_speed = '1;
                    2:       t.vehicle_speed = SPEED_W'($urandom_range(220, 255));
                    default: t.vehicle_speed = SPEED_W'($urandom_range(0, 255));
                endcase
                t.source_speed  = ($urandom_range(0, 7) == 0) ? '0 :
                                  SPEED_W'($urandom_range(0, 255));
                t.ignition_on   = ($urandom_range(0, 99) >= 6);
                t.clear_average = ($urandom_range(0, 99) < 3);
                send_request(t, 1'b0, '0);
            end
            req_if.valid <= 1'b0;
        end

        // Wait out the last results, then allow for any stray one.
        while (expected_readouts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (%0d directed) under %0d display cap settings,",
                 requests_sent, NUM_DRILLS, NUM_PHASES + 1);
        $display("with %0d results checked and %0d long result stall(s).",
                 results_checked, long_holds);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
